>>> rtl/msc_pkg.sv
package msc_pkg;

	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 5;

	// Table depth; every index is sized from it.
	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_ZERO_M   = 2'd2;
	localparam logic [STAT_W-1:0] ST_TOO_FEW  = 2'd3;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_EVOLVE = 1'b1;

	localparam logic [1:0] REG_K    = 2'd0;
	localparam logic [1:0] REG_REST = 2'd1;
	localparam logic [1:0] REG_DT   = 2'd2;

	typedef struct packed {
		logic        action;
		logic [31:0] point_mass;
		logic [31:0] point_position;
		logic [31:0] point_velocity;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  count;
		logic [31:0] out_position;
		logic [31:0] out_velocity;
		logic [31:0] out_mass;
		logic        last;
	} rsp_t;

	// Saturate a signed 66-bit value to 32 bits.
	function automatic logic [31:0] sat32(input logic signed [65:0] v);
		logic [31:0] r;
		if (v > 66'sd2147483647)
			r = 32'h7fff_ffff;
		else if (v < -66'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

>>> rtl/msc_div.sv
// Restoring divider, one quotient bit per cycle.
module msc_div
	import msc_pkg::*;
#(
	parameter int NUM_W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [31:0]      den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q;
	logic [32:0]      r_q;
	logic [31:0]      d_q;
	logic [CW-1:0]    n_q;
	logic             busy_q;
	logic [32:0]      trial;
	logic [32:0]      diff;

	assign trial = {r_q[31:0], q_q[NUM_W-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q    <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= CW'(NUM_W);
			end else if (busy_q) begin
				n_q <= n_q - 1'b1;
				if (n_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!diff[32]) begin
				r_q <= diff;
				q_q <= {q_q[NUM_W-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule

>>> rtl/msc_datapath.sv
module msc_datapath
	import msc_pkg::*;
#(
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [4:0]  cmd,
	input  logic [IDX_W-1:0] idx,
	input  logic [4:0]  n,
	input  req_t        req_q,
	input  logic [31:0] k_q,
	input  logic [31:0] rest_q,
	input  logic [31:0] dt_q,
	output logic        rd_gt,
	output logic        div_done,
	output logic [31:0] px,
	output logic [31:0] pv,
	output logic [31:0] pm
);
	localparam int IW = IDX_W;
	localparam int NW = 32 + FRAC_BITS;

	// Commands (one-hot, from controller)
	// cmd[0] read entry idx; cmd[1] shift idx -> idx+1; cmd[2] write new at idx
	// cmd[3] start force/divide for idx; cmd[4] step arithmetic / write back

	logic [31:0] pos_m [MAX_POINTS];
	logic [31:0] vel_m [MAX_POINTS];
	logic [31:0] mas_m [MAX_POINTS];
	logic [31:0] npos_m [MAX_POINTS];
	logic [31:0] nvel_m [MAX_POINTS];

	logic [31:0] rx_q, rv_q, rm_q;
	logic [31:0] xl_q, xr_q;
	logic signed [65:0] net_q;
	logic        neg_q;
	logic [NW-1:0] quo;
	logic        dstart;
	logic [3:0]  ph_q;
	logic signed [65:0] acc_q, adt_q, vdt_q, half_q;

	function automatic logic signed [65:0] mulq(input logic signed [65:0] a,
		input logic [31:0] b);
		logic [65:0] mag;
		logic [97:0] p;
		mag = a[65] ? 66'(-a) : 66'(a);
		p = 98'(mag[33:0]) * 98'(b);
		p = p >> FRAC_BITS;
		return a[65] ? -$signed(66'(p)) : $signed(66'(p));
	endfunction

	function automatic logic signed [65:0] spring(input logic [31:0] a,
		input logic [31:0] b);
		logic signed [65:0] d;
		d = 66'($signed(a)) - 66'($signed(b));
		if (d < 0) d = -d;
		return mulq(d - $signed({34'd0, rest_q}), k_q);
	endfunction

	always_ff @(posedge clk) begin
		if (cmd[0]) begin
			rx_q <= pos_m[idx];
			rv_q <= vel_m[idx];
			rm_q <= mas_m[idx];
			xl_q <= (idx != '0) ? pos_m[idx - 1'b1] : pos_m[idx];
			xr_q <= (5'(idx) + 5'd1 < n) ? pos_m[IW'(5'(idx) + 5'd1)] : pos_m[idx];
		end
		if (cmd[1]) begin
			pos_m[idx + 1'b1] <= pos_m[idx];
			vel_m[idx + 1'b1] <= vel_m[idx];
			mas_m[idx + 1'b1] <= mas_m[idx];
		end
		if (cmd[2]) begin
			pos_m[idx] <= req_q.point_position;
			vel_m[idx] <= req_q.point_velocity;
			mas_m[idx] <= req_q.point_mass;
		end
		if (cmd[3]) begin
			net_q <= $signed(66'($signed(sat32(
				((5'(idx) + 5'd1 < n) ? spring(rx_q, xr_q) : 66'sd0) -
				((idx != '0) ? spring(xl_q, rx_q) : 66'sd0)))));
			// Left neighbour has been read: retire the previous point.
			if (idx != '0) begin
				pos_m[idx - 1'b1] <= npos_m[idx - 1'b1];
				vel_m[idx - 1'b1] <= nvel_m[idx - 1'b1];
			end
		end
		if (cmd[4]) begin
			case (ph_q)
				4'd0: acc_q <= neg_q ? -$signed(66'(quo > NW'(33'h80000000) ?
					NW'(33'h80000000) : quo)) : $signed(66'(quo > NW'(32'h7fffffff) ?
					NW'(32'h7fffffff) : quo));
				4'd1: adt_q <= $signed(66'($signed(sat32(mulq(acc_q, dt_q)))));
				4'd2: vdt_q <= mulq(66'($signed(rv_q)), dt_q);
				4'd3: half_q <= mulq(adt_q, dt_q) / 2;
				4'd4: begin
					nvel_m[idx] <= sat32(66'($signed(rv_q)) + adt_q);
					npos_m[idx] <= sat32(66'($signed(rx_q)) + vdt_q + half_q);
				end
				4'd5: begin
					if (5'(idx) + 5'd1 == n) begin
						pos_m[idx] <= npos_m[idx];
						vel_m[idx] <= nvel_m[idx];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= '0;
			dstart <= 1'b0;
			neg_q  <= 1'b0;
		end else begin
			dstart <= cmd[3];
			if (cmd[3]) ph_q <= '0;
			else if (cmd[4]) ph_q <= ph_q + 1'b1;
			if (dstart) neg_q <= net_q[65];
		end
	end

	logic [31:0] nmag;
	assign nmag = net_q[65] ? 32'(-net_q) : net_q[31:0];

	msc_div #(.NUM_W(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart),
		.num({nmag, {FRAC_BITS{1'b0}}}), .den(rm_q),
		.done(div_done), .quo(quo)
	);

	assign rd_gt = $signed(rx_q) > $signed(req_q.point_position);
	assign px = (ph_q == 4'd5) ? npos_m[idx] : rx_q;
	assign pv = (ph_q == 4'd5) ? nvel_m[idx] : rv_q;
	assign pm = rm_q;
endmodule

>>> rtl/msc_ctrl.sv
module msc_ctrl
	import msc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  req_t req,
	output req_t req_q,
	output logic [4:0] cmd,
	output logic [IDX_W-1:0] idx,
	output logic [4:0] n_q,
	input  logic rd_gt,
	input  logic div_done,
	output logic busy,
	output logic emit,
	output logic [1:0] st,
	output logic lst,
	input  logic out_free
);
	localparam int IW = IDX_W;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001, S_RD   = 9'b000000010, S_CMP  = 9'b000000100,
		S_WR   = 9'b000001000, S_EREAD= 9'b000010000, S_FRC  = 9'b000100000,
		S_DIV  = 9'b001000000, S_ARI  = 9'b010000000, S_OUT  = 9'b100000000
	} state_t;

	state_t st_q;
	logic [IW:0] i_q;
	logic [2:0]  ph_q;

	assign idx = i_q[IW-1:0];
	assign busy = st_q != S_IDLE;

	always_comb begin
		cmd  = '0;
		emit = 1'b0;
		case (st_q)
			S_RD:    cmd[0] = 1'b1;
			S_CMP:   cmd[1] = rd_gt;
			S_WR:    cmd[2] = 1'b1;
			S_EREAD: cmd[0] = 1'b1;
			S_FRC:   cmd[3] = 1'b1;
			S_ARI:   cmd[4] = 1'b1;
			S_OUT:   begin cmd[4] = out_free; emit = out_free; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) if (in_fire) req_q <= req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; n_q <= '0; i_q <= '0; ph_q <= '0;
			st <= ST_OK; lst <= 1'b0;
		end else begin
			lst <= 1'b0;
			case (st_q)
				S_IDLE: if (in_fire) begin
					if (req.action == ACT_INSERT) begin
						if (n_q >= 5'(MAX_POINTS)) begin st <= ST_FULL; lst <= 1'b1; end
						else if (req.point_mass == '0) begin st <= ST_ZERO_M; lst <= 1'b1; end
						else if (n_q == '0) begin i_q <= '0; st_q <= S_WR; end
						else begin i_q <= (IW+1)'(n_q - 5'd1); st_q <= S_RD; end
					end else if (n_q < 5'd2) begin st <= ST_TOO_FEW; lst <= 1'b1; end
					else begin i_q <= '0; st_q <= S_EREAD; end
				end
				S_RD: st_q <= S_CMP;
				S_CMP: begin
					if (rd_gt) begin
						if (i_q == '0) st_q <= S_WR;
						else begin i_q <= i_q - 1'b1; st_q <= S_RD; end
					end else begin i_q <= i_q + 1'b1; st_q <= S_WR; end
				end
				S_WR: begin
					n_q <= n_q + 1'b1; st <= ST_OK; lst <= 1'b1; st_q <= S_IDLE;
				end
				S_EREAD: st_q <= S_FRC;
				S_FRC: st_q <= S_DIV;
				S_DIV: if (div_done) begin ph_q <= '0; st_q <= S_ARI; end
				S_ARI: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 3'd4) st_q <= S_OUT;
				end
				S_OUT: if (out_free) begin
					if (5'(i_q) + 5'd1 == n_q) st_q <= S_IDLE;
					else begin i_q <= i_q + 1'b1; st_q <= S_EREAD; end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/mass_spring_chain_step.sv
// Channel  | Handshake          | Payload
// request  | req_valid/ready    | req   (req_t: action, point fields)
// result   | rsp_valid/ready    | rsp   (rsp_t: status, count, point, last)
// config   | cfg_we             | cfg_index, cfg_data
// Insert walks the table one entry at a time, a compare/shift step for each
// entry moved. Evolve runs the bit-serial divider (48 quotient bits) for
// each point. Rejects are answered from idle without a table walk.
// Reset clears count and control; stores are undefined until written.
// Results wait in the output register; evolve stalls while it is full.
// Evolve writes each point but the last back only after the next point read
// its left neighbour, so old positions feed every force.
module mass_spring_chain_step
	import msc_pkg::*;
#(
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	logic [31:0] k_q, rest_q, dt_q;
	req_t        req_q;
	logic [4:0]  cmd, n_q;
	logic [IDX_W-1:0] idx;
	logic        rd_gt, div_done, busy, emit, lst;
	logic [1:0]  st;
	logic [31:0] px, pv, pm;
	logic        in_fire, out_free;

	// Hold the request while busy or while a result still sits unread.
	assign req_ready = !busy && !rsp_valid && !lst;
	assign in_fire   = req_valid && req_ready;
	assign out_free  = !rsp_valid || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 32'd65536; rest_q <= 32'd65536; dt_q <= 32'd655;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_K:    k_q    <= cfg_data;
				REG_REST: rest_q <= cfg_data;
				REG_DT:   dt_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	msc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .req(req), .req_q(req_q),
		.cmd(cmd), .idx(idx), .n_q(n_q), .rd_gt(rd_gt), .div_done(div_done),
		.busy(busy), .emit(emit), .st(st), .lst(lst), .out_free(out_free)
	);

	msc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .idx(idx), .n(n_q), .req_q(req_q),
		.k_q(k_q), .rest_q(rest_q), .dt_q(dt_q), .rd_gt(rd_gt),
		.div_done(div_done), .px(px), .pv(pv), .pm(pm)
	);

	// Output register: single results come through lst, evolve points through emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid <= 1'b0;
		else if (lst || emit) rsp_valid <= 1'b1;
		else if (rsp_ready) rsp_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (lst) begin
			rsp.status <= st;
			rsp.count  <= n_q;
			rsp.last   <= 1'b1;
			if (st == ST_OK) begin
				rsp.out_position <= req_q.point_position;
				rsp.out_velocity <= req_q.point_velocity;
				rsp.out_mass     <= req_q.point_mass;
			end else begin
				rsp.out_position <= '0; rsp.out_velocity <= '0; rsp.out_mass <= '0;
			end
		end else if (emit) begin
			rsp.status       <= ST_OK;
			rsp.count        <= n_q;
			rsp.out_position <= px;
			rsp.out_velocity <= pv;
			rsp.out_mass     <= pm;
			rsp.last         <= 5'(idx) + 5'd1 == n_q;
		end
	end
endmodule

>>> rtl/msc_checker.sv
module msc_checker
	import msc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)) else $error("rsp dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("accept while result pending");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.count <= 5'(MAX_POINTS)) else $error("count range");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.last) else $error("reject not last");
endmodule

bind mass_spring_chain_step msc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_ready(req_ready),
	.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
